// File: design/lrupr_pkg.sv
package lrupr_pkg;

	// default geometry of the recency stack
	localparam int FRAMES_DEF    = 8;
	localparam int PAGE_BITS_DEF = 16;

	// fixed field widths
	localparam int PAGE_IN_W = 16;
	localparam int CFG_W     = 4;
	localparam int FAULT_W   = 32;

	// frame count after reset
	localparam logic [CFG_W-1:0] NUM_FRAMES_RST = CFG_W'(8);

	// per-transaction control broadcast to every cell
	typedef struct packed {
		logic take;   // a reference is accepted this cycle
		logic shift;  // hit, or miss with all frames taken: close gap and put page on top
	} lrupr_ctl_t;

endpackage

// File: design/lrupr_cell.sv
module lrupr_cell #(
	parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
	parameter int IDX       = 0
) (
	input  logic                             clk,
	input  lrupr_pkg::lrupr_ctl_t            ctl,
	input  logic [$clog2(FRAMES+1)-1:0]      count,
	input  logic [PAGE_BITS-1:0]             page,
	input  logic [PAGE_BITS-1:0]             nbr,
	input  logic                             seen_in,
	output logic                             seen_out,
	output logic                             match,
	output logic [PAGE_BITS-1:0]             val
);
	import lrupr_pkg::*;

	localparam int CW = $clog2(FRAMES + 1);
	localparam logic [CW-1:0] POS_C  = CW'(IDX);
	localparam logic [CW-1:0] POS1_C = CW'(IDX + 1);

	logic [PAGE_BITS-1:0] val_q;
	logic in_range;
	logic is_last;
	logic is_next;

	// position of this cell relative to the occupied part of the stack
	assign in_range = POS_C < count;
	assign is_last  = count == POS1_C;
	assign is_next  = count == POS_C;

	// compare and pass the shift-start mark upwards
	assign match    = in_range && (val_q == page);
	assign seen_out = seen_in | match;
	assign val      = val_q;

	// shift down from the neighbour above, or load the referenced page
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			if (ctl.shift && is_last) begin
				val_q <= page;
			end else if (ctl.shift && in_range && seen_out) begin
				val_q <= nbr;
			end else if (!ctl.shift && is_next) begin
				val_q <= page;
			end
		end
	end

endmodule

// File: design/lru_page_replacement.sv
// channel  | dir | tdata               | tuser | tlast
// s_*      | in  | [15:0] page_number  | -     | -
// m_*      | out | [31:0] fault_count  | [0] hit | -
// cfg_*    | in  | [3:0] num_frames    | -     | -
//
// one reference per cycle unless the output stalls; all cells compare and shift at once
// the result appears in the output register in the cycle after the reference is taken
// a new reference is taken while the output register is empty or being emptied
// reset empties the stack, clears the fault counter and sets num_frames to 8
// stack contents are not reset; only entries below the occupied count are compared
module lru_page_replacement #(
	parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lrupr_pkg::PAGE_IN_W-1:0]  s_tdata,   // [15:0] page_number
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lrupr_pkg::FAULT_W-1:0]    m_tdata,   // [31:0] fault_count
	output logic                             m_tuser,   // [0] hit
	input  logic                             cfg_we,
	input  logic [lrupr_pkg::CFG_W-1:0]      cfg_wdata  // [3:0] num_frames
);
	import lrupr_pkg::*;

	localparam int CW = $clog2(FRAMES + 1);

	logic [CFG_W-1:0]     num_frames_q;
	logic [CW-1:0]        count_q;
	logic [FAULT_W-1:0]   fault_q;
	logic                 out_valid_q;
	logic                 out_hit_q;
	logic [FAULT_W-1:0]   out_fault_q;

	logic [PAGE_BITS-1:0] page;
	logic [CW-1:0]        limit;
	logic                 full;
	logic                 take;
	logic                 hit;
	logic [FAULT_W-1:0]   fault_nxt;
	lrupr_ctl_t           ctl;

	logic [FRAMES-1:0]    match;
	logic [FRAMES-1:0]    seen;
	logic [PAGE_BITS-1:0] vals [FRAMES];

	// input side
	assign page     = PAGE_BITS'(s_tdata);
	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;

	// effective frame count: zero acts as one, above FRAMES acts as FRAMES
	always_comb begin
		if (num_frames_q == '0) begin
			limit = CW'(1);
		end else if (32'(num_frames_q) > 32'(FRAMES)) begin
			limit = CW'(FRAMES);
		end else begin
			limit = CW'(num_frames_q);
		end
	end

	assign full      = count_q >= limit;
	assign hit       = |match;
	assign ctl.take  = take;
	assign ctl.shift = hit || full;
	assign fault_nxt = (hit || fault_q == '1) ? fault_q : fault_q + FAULT_W'(1);

	// row of cells, shift mark starts at the bottom on an eviction
	assign seen[0] = !hit;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		logic [PAGE_BITS-1:0] nbr;
		logic                 seen_out;

		if (i < FRAMES - 1) begin : g_mid
			assign nbr         = vals[i+1];
			assign seen[i+1]   = seen_out;
		end else begin : g_top
			assign nbr = '0;
		end

		lrupr_cell #(
			.FRAMES    (FRAMES),
			.PAGE_BITS (PAGE_BITS),
			.IDX       (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.count    (count_q),
			.page     (page),
			.nbr      (nbr),
			.seen_in  (seen[i]),
			.seen_out (seen_out),
			.match    (match[i]),
			.val      (vals[i])
		);
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_frames_q <= NUM_FRAMES_RST;
		end else if (cfg_we) begin
			num_frames_q <= cfg_wdata;
		end
	end

	// occupancy and fault counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fault_q <= '0;
		end else if (take) begin
			fault_q <= fault_nxt;
			if (!hit && !full) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (take) begin
			out_hit_q   <= hit;
			out_fault_q <= fault_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_hit_q;
	assign m_tdata  = out_fault_q;

`ifndef SYNTH
	// occupancy never goes past the number of cells
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(FRAMES))
		else $error("occupied count exceeds frame count");

	// a page is held in at most one occupied cell
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("page resident in more than one frame");

	// a miss advances the fault counter unless it is saturated
	a_fault_step: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !hit) |=> (fault_q == $past(fault_q) + FAULT_W'(1)) || ($past(fault_q) == '1))
		else $error("fault counter did not advance on a miss");

	// a hit leaves the occupancy unchanged
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(take && hit) |=> $stable(count_q))
		else $error("occupancy changed on a hit");
`endif

endmodule
